[src/dss_pkg.sv]
// Shared types and constants for the dual stack shared store.
`timescale 1ns / 1ps
`default_nettype none
package dss_pkg;
    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CFG_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_PUSH_A = 3'd0,
        MODE_POP_A  = 3'd1,
        MODE_VIEW_A = 3'd2,
        MODE_PUSH_B = 3'd3,
        MODE_POP_B  = 3'd4,
        MODE_VIEW_B = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_STATUS = 2'd1,
        OP_WALK   = 2'd2
    } op_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_WALK = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t                    op;
        logic [IDX_W-1:0]       addr;
        logic [IDX_W-1:0]       stop;
        logic                   up;
        status_t                status;
        logic [DATA_WIDTH-1:0]  value;
    } cmd_t;
endpackage
`default_nettype wire

[src/dss_front.sv]
// Front end: accepts words, tracks both stack boundaries, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module dss_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [2:0]                     mode,
    input  wire logic [dss_pkg::DATA_WIDTH-1:0] push_value,
    input  wire logic                           cfg_valid,
    input  wire logic [dss_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           q_full,
    output dss_pkg::cmd_t                       q_cmd,
    output logic                                q_push
);
    import dss_pkg::*;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next;
    logic [CNT_W-1:0] base_b_reg, base_b_next;
    logic [CNT_W-1:0] cfg_ext;
    logic             take;
    logic             known;

    assign take    = start && !q_full;
    assign cfg_ext = CNT_W'(cfg_data);

    always_comb
    begin
        cap_next     = cap_reg;
        count_a_next = count_a_reg;
        base_b_next  = base_b_reg;
        known        = 1'b1;
        q_cmd.op     = OP_STATUS;
        q_cmd.addr   = '0;
        q_cmd.stop   = '0;
        q_cmd.up     = 1'b0;
        q_cmd.status = ST_OK;
        q_cmd.value  = push_value;
        unique case (mode)
            MODE_PUSH_A:
            begin
                if (count_a_reg >= base_b_reg)
                begin
                    q_cmd.status = ST_OVERFLOW;
                end
                else
                begin
                    q_cmd.op     = OP_WRITE;
                    q_cmd.addr   = count_a_reg[IDX_W-1:0];
                    count_a_next = count_a_reg + 1'b1;
                end
            end
            MODE_POP_A:
            begin
                if (count_a_reg == '0)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else
                begin
                    q_cmd.op     = OP_WALK;
                    q_cmd.addr   = count_a_next[IDX_W-1:0];
                    q_cmd.stop   = count_a_next[IDX_W-1:0];
                    count_a_next = count_a_reg - 1'b1;
                    q_cmd.addr   = count_a_next[IDX_W-1:0];
                    q_cmd.stop   = count_a_next[IDX_W-1:0];
                end
            end
            MODE_VIEW_A:
            begin
                if (count_a_reg == '0)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else
                begin
                    q_cmd.op   = OP_WALK;
                    q_cmd.addr = IDX_W'(count_a_reg - 1'b1);
                    q_cmd.stop = '0;
                end
            end
            MODE_PUSH_B:
            begin
                if (base_b_reg <= count_a_reg || base_b_reg == '0)
                begin
                    q_cmd.status = ST_OVERFLOW;
                end
                else
                begin
                    q_cmd.op    = OP_WRITE;
                    base_b_next = base_b_reg - 1'b1;
                    q_cmd.addr  = base_b_next[IDX_W-1:0];
                end
            end
            MODE_POP_B:
            begin
                if (base_b_reg >= cap_reg)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else
                begin
                    q_cmd.op    = OP_WALK;
                    q_cmd.addr  = base_b_reg[IDX_W-1:0];
                    q_cmd.stop  = base_b_reg[IDX_W-1:0];
                    q_cmd.up    = 1'b1;
                    base_b_next = base_b_reg + 1'b1;
                end
            end
            MODE_VIEW_B:
            begin
                if (base_b_reg >= cap_reg)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else
                begin
                    q_cmd.op   = OP_WALK;
                    q_cmd.addr = base_b_reg[IDX_W-1:0];
                    q_cmd.stop = IDX_W'(cap_reg - 1'b1);
                    q_cmd.up   = 1'b1;
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        q_push = take && known;
        if (!q_push)
        begin
            count_a_next = count_a_reg;
            base_b_next  = base_b_reg;
        end
        if (cfg_valid)
        begin
            priority if (cfg_ext == '0)
                cap_next = CNT_W'(1);
            else if (cfg_ext > CNT_W'(DEPTH))
                cap_next = CNT_W'(DEPTH);
            else
                cap_next = cfg_ext;
            count_a_next = '0;
            base_b_next  = cap_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CNT_W'(DEPTH);
            count_a_reg <= '0;
            base_b_reg  <= CNT_W'(DEPTH);
        end
        else
        begin
            cap_reg     <= cap_next;
            count_a_reg <= count_a_next;
            base_b_reg  <= base_b_next;
        end
    end
endmodule
`default_nettype wire

[src/dss_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module dss_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dss_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output dss_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);
    import dss_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[src/dss_back.sv]
// Back end: owns the shared store, runs writes, reads and walks, drives results.
`timescale 1ns / 1ps
`default_nettype none
module dss_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dss_pkg::cmd_t                  head,
    input  wire logic                           empty,
    output logic                                pop,
    output logic                                strobe,
    output logic [dss_pkg::DATA_WIDTH-1:0]      data,
    output logic [1:0]                          status,
    output logic                                last
);
    import dss_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] stop_reg, stop_next;
    logic             up_reg, up_next;

    logic             strobe_reg, strobe_next;
    status_t          status_reg, status_next;
    logic             last_reg, last_next;
    logic             from_mem_reg, from_mem_next;

    logic             we;
    logic             re;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] cur_stop;
    logic             cur_up;
    logic             walk_done;

    assign cur      = (state_reg == BK_WALK) ? addr_reg : head.addr;
    assign cur_stop = (state_reg == BK_WALK) ? stop_reg : head.stop;
    assign cur_up   = (state_reg == BK_WALK) ? up_reg : head.up;
    assign walk_done = (cur == cur_stop);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty && head.op == OP_WALK && !walk_done)
                    state_next = BK_WALK;
            end
            BK_WALK:
            begin
                if (walk_done)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        ra            = cur;
        strobe_next   = 1'b0;
        status_next   = ST_OK;
        last_next     = 1'b1;
        from_mem_next = 1'b0;
        addr_next     = addr_reg;
        stop_next     = stop_reg;
        up_next       = up_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    strobe_next = 1'b1;
                    unique case (head.op)
                        OP_WRITE:
                        begin
                            we = 1'b1;
                        end
                        OP_STATUS:
                        begin
                            status_next = head.status;
                        end
                        OP_WALK:
                        begin
                            re            = 1'b1;
                            from_mem_next = 1'b1;
                            last_next     = walk_done;
                        end
                        default:
                        begin
                            status_next = head.status;
                        end
                    endcase
                end
            end
            BK_WALK:
            begin
                re            = 1'b1;
                from_mem_next = 1'b1;
                strobe_next   = 1'b1;
                last_next     = walk_done;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
        if (re)
        begin
            addr_next = cur_up ? cur + 1'b1 : cur - 1'b1;
            stop_next = cur_stop;
            up_next   = cur_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[head.addr] <= head.value;
        if (re)
            mem_q_reg <= mem[ra];
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        stop_reg <= stop_next;
        up_reg   <= up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            strobe_reg   <= 1'b0;
            status_reg   <= ST_OK;
            last_reg     <= 1'b0;
            from_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            strobe_reg   <= strobe_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
            from_mem_reg <= from_mem_next;
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign last   = last_reg;
    assign data   = from_mem_reg ? mem_q_reg : '0;
endmodule
`default_nettype wire

[src/dual_stack_shared_store.sv]
// Top level of the dual stack shared store.
//
//   channel   handshake             word
//   input     start / busy          mode, push_value
//   config    cfg_valid / cfg_ready cfg_data (capacity)
//   result    strobe                data, status, last
//
// A view of n elements makes one store read each, and the back end pops no
// new command until it ends. With the queue empty, a taken word is first
// written into the queue and the back end then registers its result. A
// two-entry command queue lets the front take words while the back walks;
// busy is high while that queue is full. After reset both stacks are empty
// and capacity is the full store. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module dual_stack_shared_store (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [2:0]                            mode,
    input  wire logic signed [dss_pkg::DATA_WIDTH-1:0] push_value,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dss_pkg::CFG_W-1:0]             cfg_data,
    output logic                                       strobe,
    output logic signed [dss_pkg::DATA_WIDTH-1:0]      data,
    output logic [1:0]                                 status,
    output logic                                       last
);
    import dss_pkg::*;

    cmd_t                  q_cmd;
    cmd_t                  q_head;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_empty;
    logic                  q_full;
    logic [DATA_WIDTH-1:0] data_w;

    assign busy      = q_full;
    assign cfg_ready = 1'b1;
    assign data      = data_w;

    dss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .push_value (push_value),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_cmd      (q_cmd),
        .q_push     (q_push)
    );

    dss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dss_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .strobe (strobe),
        .data   (data_w),
        .status (status),
        .last   (last)
    );
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the dual stack shared store: directed table, then random words.
`timescale 1ns / 1ps
module tb;
    import dss_pkg::*;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data;
        status_t                      status;
        logic                         last;
    } result_t;

    typedef enum logic {
        ROW_WORD = 1'b0,
        ROW_CAP  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [2:0]            mode;
        logic [DATA_WIDTH-1:0] value;
        logic                  typed;
        result_t               res;
    } row_t;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PLAN_LEN       = 25;
    localparam int PHASES         = 3;
    localparam int PHASE_SEGMENTS = 3;
    localparam int SEGMENT_WORDS  = 23;

    localparam result_t NO_RES    = '0;
    localparam result_t RES_OK    = '{'0, ST_OK, 1'b1};
    localparam result_t RES_OVF   = '{'0, ST_OVERFLOW, 1'b1};
    localparam result_t RES_EMPTY = '{'0, ST_EMPTY, 1'b1};

    localparam row_t PLAN [PLAN_LEN] = '{
        '{ROW_WORD, MODE_POP_A,   32'h0000_0000, 1'b1, RES_EMPTY},
        '{ROW_WORD, MODE_VIEW_A,  32'h0000_0000, 1'b1, RES_EMPTY},
        '{ROW_WORD, MODE_POP_B,   32'h0000_0000, 1'b1, RES_EMPTY},
        '{ROW_WORD, MODE_VIEW_B,  32'h0000_0000, 1'b1, RES_EMPTY},
        '{ROW_WORD, MODE_PUSH_A,  32'h7fff_ffff, 1'b1, RES_OK},
        '{ROW_WORD, MODE_PUSH_B,  32'h8000_0000, 1'b1, RES_OK},
        '{ROW_WORD, MODE_PUSH_A,  32'hffff_ffff, 1'b0, NO_RES},
        '{ROW_WORD, MODE_VIEW_A,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WORD, MODE_VIEW_B,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WORD, MODE_POP_A,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WORD, MODE_POP_A,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WORD, MODE_POP_B,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WORD, MODE_SPARE_6, 32'h1234_5678, 1'b0, NO_RES},
        '{ROW_WORD, MODE_SPARE_7, 32'hffff_ffff, 1'b0, NO_RES},
        '{ROW_CAP,  MODE_PUSH_A,  32'd2,         1'b0, NO_RES},
        '{ROW_WORD, MODE_PUSH_A,  32'd1,         1'b1, RES_OK},
        '{ROW_WORD, MODE_PUSH_B,  32'd2,         1'b1, RES_OK},
        '{ROW_WORD, MODE_PUSH_A,  32'd3,         1'b1, RES_OVF},
        '{ROW_WORD, MODE_PUSH_B,  32'd4,         1'b1, RES_OVF},
        '{ROW_WORD, MODE_VIEW_B,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_CAP,  MODE_PUSH_A,  32'd0,         1'b0, NO_RES},
        '{ROW_WORD, MODE_PUSH_B,  32'd5,         1'b1, RES_OK},
        '{ROW_WORD, MODE_PUSH_A,  32'd6,         1'b1, RES_OVF},
        '{ROW_WORD, MODE_POP_B,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_CAP,  MODE_PUSH_A,  32'd31,        1'b0, NO_RES}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [2:0]                   mode;
    logic signed [DATA_WIDTH-1:0] push_value;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_W-1:0]             cfg_data;
    logic                         strobe;
    logic signed [DATA_WIDTH-1:0] data;
    logic [1:0]                   status;
    logic                         last;

    dual_stack_shared_store uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .push_value (push_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .data       (data),
        .status     (status),
        .last       (last)
    );

    logic [DATA_WIDTH-1:0] stack_mem [DEPTH];
    logic [CNT_W-1:0]      fill_a;
    logic [CNT_W-1:0]      floor_b;
    logic [CNT_W-1:0]      cap_now;

    result_t expected_q  [$];
    result_t predicted_q [$];

    int fails;
    int words_sent;
    int results_checked;
    int cap_writes;
    int sender_idle_pct;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void add_result(input logic [DATA_WIDTH-1:0] d, input status_t s,
                                       input logic l);
        result_t r;
        r.data   = d;
        r.status = s;
        r.last   = l;
        predicted_q.push_back(r);
    endfunction

    function automatic void set_capacity(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        c = v;
        if (c == '0)
            c = CFG_W'(1);
        if (c > DEPTH)
            c = CFG_W'(DEPTH);
        cap_now = CNT_W'(c);
        fill_a  = '0;
        floor_b = cap_now;
    endfunction

    function automatic void predict_word(input logic [2:0] m, input logic [DATA_WIDTH-1:0] v);
        int i;
        predicted_q.delete();
        case (m)
            MODE_PUSH_A:
            begin
                if (fill_a >= floor_b)
                    add_result('0, ST_OVERFLOW, 1'b1);
                else
                begin
                    stack_mem[fill_a[IDX_W-1:0]] = v;
                    fill_a = fill_a + 1'b1;
                    add_result('0, ST_OK, 1'b1);
                end
            end
            MODE_POP_A:
            begin
                if (fill_a == '0)
                    add_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    fill_a = fill_a - 1'b1;
                    add_result(stack_mem[fill_a[IDX_W-1:0]], ST_OK, 1'b1);
                end
            end
            MODE_VIEW_A:
            begin
                if (fill_a == '0)
                    add_result('0, ST_EMPTY, 1'b1);
                else
                    for (i = int'(fill_a) - 1; i >= 0; i--)
                        add_result(stack_mem[IDX_W'(i)], ST_OK, i == 0);
            end
            MODE_PUSH_B:
            begin
                if (floor_b <= fill_a || floor_b == '0)
                    add_result('0, ST_OVERFLOW, 1'b1);
                else
                begin
                    floor_b = floor_b - 1'b1;
                    stack_mem[floor_b[IDX_W-1:0]] = v;
                    add_result('0, ST_OK, 1'b1);
                end
            end
            MODE_POP_B:
            begin
                if (floor_b >= cap_now)
                    add_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    add_result(stack_mem[floor_b[IDX_W-1:0]], ST_OK, 1'b1);
                    floor_b = floor_b + 1'b1;
                end
            end
            MODE_VIEW_B:
            begin
                if (floor_b >= cap_now)
                    add_result('0, ST_EMPTY, 1'b1);
                else
                    for (i = int'(floor_b); i < int'(cap_now); i++)
                        add_result(stack_mem[IDX_W'(i)], ST_OK, i + 1 == int'(cap_now));
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom_range(1) ? MODE_SPARE_7 : MODE_SPARE_6;
        if (r < 3 + push_pct)
            return $urandom_range(1) ? MODE_PUSH_B : MODE_PUSH_A;
        if ($urandom_range(99) < 60)
            return $urandom_range(1) ? MODE_POP_B : MODE_POP_A;
        return $urandom_range(1) ? MODE_VIEW_B : MODE_VIEW_A;
    endfunction

    function automatic logic [CFG_W-1:0] pick_capacity();
        case ($urandom_range(3))
            0:       return CFG_W'(DEPTH);
            1:       return $urandom_range(1) ? CFG_W'(1) : CFG_W'(0);
            2:       return CFG_W'($urandom_range(2, 6));
            default: return CFG_W'($urandom_range(31));
        endcase
    endfunction

    // entered at a falling edge with start possibly still high from the last word
    task automatic send_word(input logic [2:0] m, input logic [DATA_WIDTH-1:0] v,
                             input logic typed, input result_t typed_res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        push_value <= v;
        do
            @(posedge clk);
        while (busy);
        predict_word(m, v);
        if (typed)
            expected_q.push_back(typed_res);
        else
            foreach (predicted_q[i])
                expected_q.push_back(predicted_q[i]);
        if (m < MODE_SPARE_6)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_capacity(v);
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: data %h status %0d last %0d", data, status, last);
                fails++;
            end
            else
            begin
                want = expected_q.pop_front();
                results_checked++;
                if (data !== want.data)
                begin
                    $error("data: expected %h, got %h", want.data, data);
                    fails++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int         phase;
        int         seg;
        int         n;
        int         push_pct;
        logic [2:0] m;

        start           = 1'b0;
        mode            = '0;
        push_value      = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        fails           = 0;
        words_sent      = 0;
        results_checked = 0;
        cap_writes      = 0;
        sender_idle_pct = 22;
        foreach (stack_mem[i])
            stack_mem[i] = '0;
        cap_now = CNT_W'(DEPTH);
        fill_a  = '0;
        floor_b = cap_now;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (PLAN[r].kind == ROW_CAP)
                write_capacity(PLAN[r].value[CFG_W-1:0]);
            else
                send_word(PLAN[r].mode, PLAN[r].value, PLAN[r].typed, PLAN[r].res);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 22 : ((phase == 1) ? 86 : 0);
            for (seg = 0; seg < PHASE_SEGMENTS; seg++)
            begin
                write_capacity(pick_capacity());
                push_pct = $urandom_range(30, 60);
                n = 0;
                while (n < SEGMENT_WORDS)
                begin
                    m = pick_mode(push_pct);
                    send_word(m, pick_value(), 1'b0, NO_RES);
                    if (m < MODE_SPARE_6)
                        n++;
                end
            end
        end

        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d stack words, checked %0d results over %0d capacity writes.",
                 words_sent, results_checked, cap_writes);
        $display("Sender gaps of 22 and 86 percent and none; overflow, underflow, views.");
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
